// ----- design/pcm_pkg.sv -----
// pcm_pkg: shared sizes, configuration codes and the controller/datapath
// command and status structs of the pairwise contact map block.
// No dependencies.
package pcm_pkg;

  // block sizing
  localparam int MAX_ATOMS    = 64;
  localparam int MAX_RESIDUES = 64;
  localparam int COORD_BITS   = 24;

  // derived widths
  localparam int ATOM_IDX_BITS = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int ATOM_CNT_BITS = $clog2(MAX_ATOMS + 1);
  localparam int RES_IDX_BITS  = (MAX_RESIDUES > 1) ? $clog2(MAX_RESIDUES) : 1;
  localparam int RES_CNT_BITS  = $clog2(MAX_RESIDUES + 1);
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int SQ_BITS       = 2 * DIFF_BITS;
  localparam int SUM_BITS      = SQ_BITS + 2;

  // fixed field widths
  localparam int GROUP_BITS     = 32;
  localparam int RES_IN_BITS    = 8;
  localparam int CUTOFF_BITS    = 23;
  localparam int NRES_REG_BITS  = 7;
  localparam int C2_BITS        = 2 * CUTOFF_BITS;
  localparam int CMP_BITS       = (SUM_BITS > C2_BITS) ? SUM_BITS : C2_BITS;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  // register reset values
  localparam logic [CUTOFF_BITS-1:0]   CUTOFF_RESET = CUTOFF_BITS'(34816);
  localparam logic [GROUP_BITS-1:0]    GROUP_RESET  = GROUP_BITS'(1);
  localparam logic [NRES_REG_BITS-1:0] NRES_RESET   = NRES_REG_BITS'(64);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CUTOFF       = 2'd0,
    CFG_GROUP_MASK   = 2'd1,
    CFG_NUM_RESIDUES = 2'd2
  } cfg_index_t;

  // one stored atom
  typedef struct packed {
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic [COORD_BITS-1:0]   z;
    logic [RES_IDX_BITS-1:0] res;
  } atom_t;

  // controller to datapath
  typedef struct packed {
    logic                     store;
    logic [ATOM_IDX_BITS-1:0] store_addr;
    logic                     pair_valid;
    logic [ATOM_IDX_BITS-1:0] addr_i;
    logic [ATOM_IDX_BITS-1:0] addr_j;
    logic                     clear;
    logic [RES_IDX_BITS-1:0]  row;
    logic                     out_load;
    logic                     last_row;
    logic                     dropped;
  } pcm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic                    keep;
    logic                    busy;
    logic                    out_free;
    logic [RES_CNT_BITS-1:0] n_eff;
  } pcm_status_t;

endpackage

// ----- design/pcm_ctrl.sv -----
// pcm_ctrl: frame sequencer of the contact map block (load, clear sweep,
// pair walk, drain, row emit). Depends on pcm_pkg.
module pcm_ctrl
  import pcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        last_atom,
  input  pcm_status_t status,
  output pcm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_PAIRS,
    ST_DRAIN,
    ST_EMIT_READ,
    ST_EMIT_LOAD
  } state_t;

  state_t                   state;
  logic [ATOM_CNT_BITS-1:0] count;
  logic                     overflow;
  logic [ATOM_IDX_BITS-1:0] idx_i;
  logic [ATOM_IDX_BITS-1:0] idx_j;
  logic [RES_IDX_BITS-1:0]  row;

  logic                     accept;
  logic                     room;
  logic [ATOM_IDX_BITS-1:0] count_m1;
  logic                     is_last_row;

  assign in_stall    = (state != ST_LOAD);
  assign accept      = in_valid && (state == ST_LOAD);
  assign room        = count < ATOM_CNT_BITS'(MAX_ATOMS);
  assign count_m1    = ATOM_IDX_BITS'(count - ATOM_CNT_BITS'(1));
  assign is_last_row = (RES_CNT_BITS'(row) + RES_CNT_BITS'(1)) == status.n_eff;

  always_comb begin
    cmd            = '0;
    cmd.store      = accept && status.keep && room;
    cmd.store_addr = ATOM_IDX_BITS'(count);
    cmd.pair_valid = (state == ST_PAIRS);
    cmd.addr_i     = idx_i;
    cmd.addr_j     = idx_j;
    cmd.clear      = (state == ST_CLEAR);
    cmd.row        = row;
    cmd.out_load   = (state == ST_EMIT_LOAD) && status.out_free;
    cmd.last_row   = is_last_row;
    cmd.dropped    = overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
      idx_i    <= '0;
      idx_j    <= '0;
      row      <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (status.keep) begin
              if (room) count <= count + ATOM_CNT_BITS'(1);
              else overflow <= 1'b1;
            end
            if (last_atom) begin
              row   <= '0;
              state <= ST_CLEAR;
            end
          end
        end
        ST_CLEAR: begin
          if (row == RES_IDX_BITS'(MAX_RESIDUES - 1)) begin
            row   <= '0;
            idx_i <= '0;
            idx_j <= '0;
            state <= (count == '0) ? ST_DRAIN : ST_PAIRS;
          end else begin
            row <= row + RES_IDX_BITS'(1);
          end
        end
        ST_PAIRS: begin
          if (idx_j == count_m1) begin
            if (idx_i == count_m1) begin
              state <= ST_DRAIN;
            end else begin
              idx_i <= idx_i + ATOM_IDX_BITS'(1);
              idx_j <= idx_i + ATOM_IDX_BITS'(1);
            end
          end else begin
            idx_j <= idx_j + ATOM_IDX_BITS'(1);
          end
        end
        ST_DRAIN: begin
          if (!status.busy) state <= ST_EMIT_READ;
        end
        ST_EMIT_READ: begin
          state <= ST_EMIT_LOAD;
        end
        ST_EMIT_LOAD: begin
          if (status.out_free) begin
            if (is_last_row) begin
              count    <= '0;
              overflow <= 1'b0;
              row      <= '0;
              state    <= ST_LOAD;
            end else begin
              row   <= row + RES_IDX_BITS'(1);
              state <= ST_EMIT_READ;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ATOM_CNT_BITS'(MAX_ATOMS))
    else $error("atom count beyond store depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (count == ATOM_CNT_BITS'(MAX_ATOMS)))
    else $error("overflow flagged with room left in store");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    cmd.pair_valid |-> (idx_i <= idx_j))
    else $error("pair issued with i above j");

  a_map_settled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_READ) |-> !status.busy)
    else $error("map read while pair pipeline still writing");
`endif

endmodule

// ----- design/pcm_datapath.sv -----
// pcm_datapath: configuration registers, atom store, distance pipeline,
// the two triangular map memories and the output register. Depends on pcm_pkg.
module pcm_datapath
  import pcm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [GROUP_BITS-1:0]     atom_group_bits,
  input  logic [RES_IN_BITS-1:0]    residue_number,
  input  logic [COORD_BITS-1:0]     x_coord,
  input  logic [COORD_BITS-1:0]     y_coord,
  input  logic [COORD_BITS-1:0]     z_coord,
  input  pcm_cmd_t                  cmd,
  output pcm_status_t               status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RES_IDX_BITS-1:0]   row_index,
  output logic [MAX_RESIDUES-1:0]   row_bits,
  output logic                      last_row,
  output logic                      atoms_dropped
);

  logic [CUTOFF_BITS-1:0]   cutoff;
  logic [GROUP_BITS-1:0]    gmask;
  logic [NRES_REG_BITS-1:0] nres;
  logic [C2_BITS-1:0]       cutoff_sq;
  logic [RES_CNT_BITS-1:0]  n_eff;

  atom_t                    atom_mem [MAX_ATOMS];
  atom_t                    rd_i;
  atom_t                    rd_j;
  logic                     s1_v;

  logic signed [DIFF_BITS-1:0] dx, dy, dz;
  logic [DIFF_BITS-1:0]     ax, ay, az;
  logic [RES_IDX_BITS-1:0]  res_lo, res_hi;
  logic                     s2_v;

  logic [SQ_BITS-1:0]       sqx, sqy, sqz;
  logic [RES_IDX_BITS-1:0]  s3_lo, s3_hi;
  logic                     s3_v;

  logic [SUM_BITS-1:0]      dist_sq;
  logic                     contact;

  logic [MAX_RESIDUES-1:0]  map_upper [MAX_RESIDUES];
  logic [MAX_RESIDUES-1:0]  map_lower [MAX_RESIDUES];
  logic [MAX_RESIDUES-1:0]  upper_rd;
  logic [MAX_RESIDUES-1:0]  lower_rd;
  logic [MAX_RESIDUES-1:0]  ge_mask;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= CUTOFF_RESET;
      gmask  <= GROUP_RESET;
      nres   <= NRES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUTOFF:       cutoff <= cfg_data[CUTOFF_BITS-1:0];
        CFG_GROUP_MASK:   gmask  <= cfg_data[GROUP_BITS-1:0];
        CFG_NUM_RESIDUES: nres   <= cfg_data[NRES_REG_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // squared cutoff, settles long before the pair walk starts
  always_ff @(posedge clk) begin
    cutoff_sq <= C2_BITS'(cutoff) * C2_BITS'(cutoff);
  end

  always_comb begin
    if (nres == '0) n_eff = RES_CNT_BITS'(1);
    else if (nres > NRES_REG_BITS'(MAX_RESIDUES)) n_eff = RES_CNT_BITS'(MAX_RESIDUES);
    else n_eff = RES_CNT_BITS'(nres);
  end

  assign status.n_eff    = n_eff;
  assign status.keep     = ((atom_group_bits & gmask) != '0) && (residue_number != '0) &&
                           (residue_number <= RES_IN_BITS'(n_eff));
  assign status.busy     = cmd.pair_valid || s1_v || s2_v || s3_v;
  assign status.out_free = !out_valid || !out_stall;

  // atom store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      atom_mem[cmd.store_addr] <= '{x: x_coord, y: y_coord, z: z_coord,
                                    res: RES_IDX_BITS'(residue_number - RES_IN_BITS'(1))};
    end
    rd_i <= atom_mem[cmd.addr_i];
    rd_j <= atom_mem[cmd.addr_j];
  end

  // stage 2: coordinate differences and magnitudes
  always_comb begin
    dx = $signed({rd_i.x[COORD_BITS-1], rd_i.x}) - $signed({rd_j.x[COORD_BITS-1], rd_j.x});
    dy = $signed({rd_i.y[COORD_BITS-1], rd_i.y}) - $signed({rd_j.y[COORD_BITS-1], rd_j.y});
    dz = $signed({rd_i.z[COORD_BITS-1], rd_i.z}) - $signed({rd_j.z[COORD_BITS-1], rd_j.z});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd.pair_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    ax     <= dx[DIFF_BITS-1] ? $unsigned(-dx) : $unsigned(dx);
    ay     <= dy[DIFF_BITS-1] ? $unsigned(-dy) : $unsigned(dy);
    az     <= dz[DIFF_BITS-1] ? $unsigned(-dz) : $unsigned(dz);
    res_lo <= (rd_i.res < rd_j.res) ? rd_i.res : rd_j.res;
    res_hi <= (rd_i.res < rd_j.res) ? rd_j.res : rd_i.res;
  end

  // stage 3: one multiplier per axis
  always_ff @(posedge clk) begin
    sqx   <= SQ_BITS'(ax) * SQ_BITS'(ax);
    sqy   <= SQ_BITS'(ay) * SQ_BITS'(ay);
    sqz   <= SQ_BITS'(az) * SQ_BITS'(az);
    s3_lo <= res_lo;
    s3_hi <= res_hi;
  end

  // stage 4: sum, compare, map write
  assign dist_sq = SUM_BITS'(sqx) + SUM_BITS'(sqy) + SUM_BITS'(sqz);
  assign contact = CMP_BITS'(dist_sq) < CMP_BITS'(cutoff_sq);

  // upper map holds cell (lo, hi) at row lo, lower map the mirror at row hi
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      map_upper[cmd.row] <= '0;
      map_lower[cmd.row] <= '0;
    end else if (s3_v) begin
      map_upper[s3_lo][s3_hi] <= contact;
      map_lower[s3_hi][s3_lo] <= contact;
    end
    upper_rd <= map_upper[cmd.row];
    lower_rd <= map_lower[cmd.row];
  end

  assign ge_mask = {MAX_RESIDUES{1'b1}} << cmd.row;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      row_index     <= cmd.row;
      row_bits      <= (upper_rd & ge_mask) | (lower_rd & ~ge_mask);
      last_row      <= cmd.last_row;
      atoms_dropped <= cmd.dropped;
    end
  end

`ifndef SYNTHESIS
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    s3_v |-> !cmd.clear)
    else $error("map write collides with clear sweep");
`endif

endmodule

// ----- design/pairwise_contact_map.sv -----
// pairwise_contact_map: non-last items are accepted while loading; a last item
// runs a clear of every map row, then a walk over all stored atom pairs i <= j
// at one pair per cycle (atom store read ports), a pipeline drain, then the rows
// in order, each read from the maps and loaded into the output register once it
// is free. No item is taken meanwhile. Synchronous active-high rst clears control,
// frame counters, config registers and out_valid; stores are rewritten before use.
module pairwise_contact_map
  import pcm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // atom input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [GROUP_BITS-1:0]     atom_group_bits,
  input  logic [RES_IN_BITS-1:0]    residue_number,
  input  logic [COORD_BITS-1:0]     x_coord,
  input  logic [COORD_BITS-1:0]     y_coord,
  input  logic [COORD_BITS-1:0]     z_coord,
  input  logic                      last_atom,
  // map row output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RES_IDX_BITS-1:0]   row_index,
  output logic [MAX_RESIDUES-1:0]   row_bits,
  output logic                      last_row,
  output logic                      atoms_dropped
);

  // commands go one way, status the other; nothing else crosses
  pcm_cmd_t    cmd;
  pcm_status_t status;

  // sequencer: owns atom count, overflow flag and all loop counters
  pcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_atom (last_atom),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: config, atom store, 4-stage distance pipeline, map memories,
  // output register that lets the next frame load while the last row waits
  pcm_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .atom_group_bits (atom_group_bits),
    .residue_number  (residue_number),
    .x_coord         (x_coord),
    .y_coord         (y_coord),
    .z_coord         (z_coord),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .row_index       (row_index),
    .row_bits        (row_bits),
    .last_row        (last_row),
    .atoms_dropped   (atoms_dropped)
  );

endmodule
